// ----- rtl/core/pidtm_pkg.sv -----
// pidtm_pkg: shared types and constants for the three-mode pid controller
`default_nettype none
package pidtm_pkg;

   // sample and register widths
   localparam int SAMPLE_WIDTH = 16;
   localparam int GAIN_W       = 16;
   localparam int ICAP_W       = 24;
   localparam int DCAP_W       = 15;
   localparam int DBAND_W      = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 24;

   // derived state widths
   localparam int ERR_W   = SAMPLE_WIDTH + 1;  // target - measured
   localparam int ESUM_W  = ICAP_W + 1;        // clamped error sum
   localparam int SLOPE_W = ERR_W + 1 + 8;     // q.8 filtered derivative

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_FF = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ICAP    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DCAP    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_DBAND   = 3'd7;

   // controller modes, the unused code behaves as positional
   localparam logic [1:0] MODE_INCR = 2'd0;
   localparam logic [1:0] MODE_POS  = 2'd1;
   localparam logic [1:0] MODE_FF   = 2'd2;

   // derivative low-pass coefficients, 0.2 and 0.8 in q.8
   localparam logic signed [7:0] FILT_NEW   = 8'sd51;
   localparam logic signed [8:0] FILT_OLD   = 9'sd205;
   localparam int                FILT_SHIFT = 8;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] measured;
      logic signed [SAMPLE_WIDTH-1:0] target;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] drive;
      logic                           in_dead_band;
   } rsp_type;

   typedef struct packed {
      logic [1:0]               mode;
      logic signed [GAIN_W-1:0] gain_p;
      logic signed [GAIN_W-1:0] gain_i;
      logic signed [GAIN_W-1:0] gain_d;
      logic signed [GAIN_W-1:0] gain_ff;
      logic [ICAP_W-1:0]        integral_cap;
      logic [DCAP_W-1:0]        drive_cap;
      logic [DBAND_W-1:0]       dead_band;
   } cfg_type;

   typedef struct packed {
      logic signed [ERR_W-1:0]        prev_error;
      logic signed [ERR_W-1:0]        prev_prev_error;
      logic signed [ESUM_W-1:0]       error_sum;
      logic signed [SLOPE_W-1:0]      smoothed_slope;
      logic signed [SAMPLE_WIDTH-1:0] prev_target;
   } state_type;

endpackage
`default_nettype wire

// ----- rtl/core/pidtm_datapath.sv -----
// pidtm_datapath: one-pass pid arithmetic, result and next controller state
`default_nettype none
module pidtm_datapath #(
   parameter int GAIN_FRAC_BITS = 8
) (
   input  wire pidtm_pkg::cfg_type   cfg,
   input  wire pidtm_pkg::req_type   item,
   input  wire pidtm_pkg::state_type state_cur,
   output pidtm_pkg::rsp_type        result,
   output pidtm_pkg::state_type      state_nxt
);
   import pidtm_pkg::*;

   localparam int D1_W    = ERR_W + 1;
   localparam int D2_W    = ERR_W + 2;
   localparam int ACC_E_W = ESUM_W + 1;
   localparam int OLD_W   = SLOPE_W + 9;
   localparam int P_W     = GAIN_W + D2_W;
   localparam int I_W     = GAIN_W + ESUM_W;
   localparam int D_W     = GAIN_W + SLOPE_W;
   localparam int F_W     = GAIN_W + ERR_W;
   localparam int TOT_W   = D_W + 3;

   logic               is_incr, is_ff, dead;
   logic signed [ERR_W-1:0]   err, tgt_delta;
   logic        [ERR_W-1:0]   err_mag;
   logic signed [D1_W-1:0]    diff1;
   logic signed [D2_W-1:0]    diff2;
   logic signed [ACC_E_W-1:0] esum_raw, icap_acc;
   logic signed [ESUM_W-1:0]  esum_clamped;
   logic signed [OLD_W-1:0]   slope_old;
   logic signed [SLOPE_W:0]   slope_sum;
   logic signed [SLOPE_W-1:0] slope_new;
   logic signed [D2_W-1:0]    p_opnd;
   logic signed [ESUM_W-1:0]  i_opnd;
   logic signed [SLOPE_W-1:0] d_opnd;
   logic signed [P_W-1:0]     p_prod;
   logic signed [I_W-1:0]     i_prod, i_shift, icap_i;
   logic signed [D_W-1:0]     d_prod;
   logic signed [F_W-1:0]     f_prod;
   logic signed [TOT_W-1:0]   p_term, i_term, d_term, f_term, total, dcap_t, total_clamped;

   assign is_incr = (cfg.mode == MODE_INCR);
   assign is_ff   = (cfg.mode == MODE_FF);

   // error and its differences
   assign err       = ERR_W'(item.target) - ERR_W'(item.measured);
   assign tgt_delta = ERR_W'(item.target) - ERR_W'(state_cur.prev_target);
   assign diff1     = D1_W'(err) - D1_W'(state_cur.prev_error);
   assign diff2     = D2_W'(err) - (D2_W'(state_cur.prev_error) <<< 1)
                      + D2_W'(state_cur.prev_prev_error);

   assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
   assign dead    = is_ff && (err_mag < ERR_W'(cfg.dead_band));

   // integral accumulator with symmetric anti-windup clamp
   assign esum_raw = ACC_E_W'(state_cur.error_sum) + ACC_E_W'(err);
   assign icap_acc = $signed(ACC_E_W'(cfg.integral_cap));
   always_comb begin
      if (esum_raw > icap_acc) begin
         esum_clamped = ESUM_W'(icap_acc);
      end else if (esum_raw < -icap_acc) begin
         esum_clamped = ESUM_W'(-icap_acc);
      end else begin
         esum_clamped = ESUM_W'(esum_raw);
      end
   end

   // low-pass on the raw slope in q.8, the new sample term is the raw slope times FILT_NEW
   assign slope_old = OLD_W'(state_cur.smoothed_slope) * FILT_OLD;
   assign slope_sum = (SLOPE_W + 1)'(diff1) * FILT_NEW
                      + (SLOPE_W + 1)'(slope_old >>> FILT_SHIFT);
   assign slope_new = SLOPE_W'(slope_sum);

   // gain multiplier operands
   assign p_opnd = is_incr ? D2_W'(diff1) : D2_W'(err);
   assign i_opnd = is_incr ? ESUM_W'(err) : esum_clamped;
   always_comb begin
      if (is_incr) begin
         d_opnd = SLOPE_W'(diff2);
      end else if (is_ff) begin
         d_opnd = slope_new;
      end else begin
         d_opnd = SLOPE_W'(diff1);
      end
   end

   assign p_prod = P_W'(cfg.gain_p) * P_W'(p_opnd);
   assign i_prod = I_W'(cfg.gain_i) * I_W'(i_opnd);
   assign d_prod = D_W'(cfg.gain_d) * D_W'(d_opnd);
   assign f_prod = F_W'(cfg.gain_ff) * F_W'(tgt_delta);

   // floor after dropping the fraction bits, then the incremental i term is clamped
   assign i_shift = i_prod >>> GAIN_FRAC_BITS;
   assign icap_i  = $signed(I_W'(cfg.integral_cap));
   always_comb begin
      if (is_incr && (i_shift > icap_i)) begin
         i_term = TOT_W'(icap_i);
      end else if (is_incr && (i_shift < -icap_i)) begin
         i_term = TOT_W'(-icap_i);
      end else begin
         i_term = TOT_W'(i_shift);
      end
   end

   assign p_term = TOT_W'(p_prod >>> GAIN_FRAC_BITS);
   assign d_term = is_ff ? TOT_W'(d_prod >>> (GAIN_FRAC_BITS + FILT_SHIFT))
                         : TOT_W'(d_prod >>> GAIN_FRAC_BITS);
   assign f_term = is_ff ? TOT_W'(f_prod >>> GAIN_FRAC_BITS) : '0;

   // output saturation
   assign total  = p_term + i_term + d_term + f_term;
   assign dcap_t = $signed(TOT_W'(cfg.drive_cap));
   always_comb begin
      if (total > dcap_t) begin
         total_clamped = dcap_t;
      end else if (total < -dcap_t) begin
         total_clamped = -dcap_t;
      end else begin
         total_clamped = total;
      end
   end

   always_comb begin
      result.in_dead_band = dead;
      result.drive        = dead ? '0 : SAMPLE_WIDTH'(total_clamped);
   end

   // state follows the mode, the dead band leaves everything alone
   always_comb begin
      state_nxt = state_cur;
      if (is_incr) begin
         state_nxt.prev_prev_error = state_cur.prev_error;
         state_nxt.prev_error      = err;
      end else if (is_ff) begin
         if (!dead) begin
            state_nxt.prev_error     = err;
            state_nxt.error_sum      = esum_clamped;
            state_nxt.smoothed_slope = slope_new;
            state_nxt.prev_target    = item.target;
         end
      end else begin
         state_nxt.prev_error = err;
         state_nxt.error_sum  = esum_clamped;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/pid_controller_three_mode.sv -----
// pid_controller_three_mode: top level of the fixed-point three-mode pid controller
//
// usage
//   req channel carries one item per sample: measured value and setpoint,
//   both signed. rsp channel returns one item per request: the saturated
//   drive and a flag set when the mode 2 dead band forced the drive to zero.
//   both channels are valid/ready; an item moves when valid and ready are high.
//   csr port is write only: csr_we, csr_index and csr_wdata, taken at the edge.
//   registers are to be written only while no item is in flight; not enforced by the block.
// timing
//   an item goes through an input register, then one pass of arithmetic into
//   the result register, which drives rsp_valid. one item per cycle sustained
//   while rsp_ready stays high; the controller state is updated as the item
//   leaves the input register, so the next item sees it in the input register.
// reset
//   synchronous and active high: mode reads positional, gains, caps and dead
//   band read zero, all error history and filter state is cleared.
// backpressure
//   when rsp_ready is low the result is held; the input register still takes
//   one more item, after which req_ready drops until the result is taken
`default_nettype none
module pid_controller_three_mode #(
   parameter int GAIN_FRAC_BITS = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire pidtm_pkg::req_type                  req_item,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output pidtm_pkg::rsp_type                       rsp_item,
   input  wire logic                                csr_we,
   input  wire logic [pidtm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pidtm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pidtm_pkg::*;

   // configuration registers
   cfg_type   cfg_ff, cfg_in;
   // controller history
   state_type state_ff, state_in;
   // input stage
   logic      in_valid_ff, in_valid_in;
   req_type   in_item_ff, in_item_in;
   // result stage
   logic      out_valid_ff, out_valid_in;
   rsp_type   out_item_ff, out_item_in;

   logic      advance, req_take;
   rsp_type   calc_result;
   state_type calc_state;

   pidtm_datapath #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_datapath (
      .cfg       (cfg_ff),
      .item      (in_item_ff),
      .state_cur (state_ff),
      .result    (calc_result),
      .state_nxt (calc_state)
   );

   // result register frees when empty or being taken
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:    cfg_in.mode         = csr_wdata[1:0];
            CSR_GAIN_P:  cfg_in.gain_p       = $signed(csr_wdata[GAIN_W-1:0]);
            CSR_GAIN_I:  cfg_in.gain_i       = $signed(csr_wdata[GAIN_W-1:0]);
            CSR_GAIN_D:  cfg_in.gain_d       = $signed(csr_wdata[GAIN_W-1:0]);
            CSR_GAIN_FF: cfg_in.gain_ff      = $signed(csr_wdata[GAIN_W-1:0]);
            CSR_ICAP:    cfg_in.integral_cap = csr_wdata[ICAP_W-1:0];
            CSR_DCAP:    cfg_in.drive_cap    = csr_wdata[DCAP_W-1:0];
            CSR_DBAND:   cfg_in.dead_band    = csr_wdata[DBAND_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   // pipeline next values
   always_comb begin
      in_item_in   = in_item_ff;
      out_item_in  = out_item_ff;
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      in_valid_in  = in_valid_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
         in_valid_in  = 1'b0;
         if (in_valid_ff) begin
            out_item_in = calc_result;
            state_in    = calc_state;
         end
      end
      if (req_take) begin
         in_item_in  = req_item;
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff              <= '{mode: MODE_POS, gain_p: '0, gain_i: '0, gain_d: '0,
                                  gain_ff: '0, integral_cap: '0, drive_cap: '0,
                                  dead_band: '0};
         state_ff            <= '0;
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
      end else begin
         cfg_ff              <= cfg_in;
         state_ff            <= state_in;
         in_valid_ff         <= in_valid_in;
         out_valid_ff        <= out_valid_in;
      end
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   // a dead-band result always carries zero drive
   a_dead_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.in_dead_band) |-> (rsp_item.drive == '0))
      else $error("dead band item with nonzero drive");

   // both stages full and stalled means no further item is taken
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input taken while both stages are held");

   // a held result keeps its item
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> (out_valid_ff && $stable(out_item_ff)))
      else $error("stalled result changed");

   // nothing is left in flight after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!out_valid_ff && !in_valid_ff))
      else $error("stage valid after reset");

endmodule
`default_nettype wire

// ----- sim/pid_controller_three_mode_tb.sv -----
// pid_controller_three_mode_tb: self-checking bench for the three-mode pid controller
`default_nettype none
module pid_controller_three_mode_tb;
   import pidtm_pkg::*;

   localparam int          GAIN_FRAC   = 8;
   localparam int          RANDOM_ITEMS = 1050;
   localparam int          CYCLE_LIMIT = 500000;
   localparam int          LONG_HOLD   = 150;
   localparam int          DRAIN_SLACK = 4;
   // the fourth mode code is not named in the package, it acts as positional
   localparam logic [1:0]  MODE_SPARE  = 2'd3;
   // derivative smoothing, 0.2 and 0.8 scaled by 256
   localparam longint      SMOOTH_NEW  = 51;
   localparam longint      SMOOTH_OLD  = 205;

   // expected-drive book: own copy of settings and controller history
   class drive_book;
      cfg_type   cfg;
      longint    last_err, older_err, err_total, slope_q8, last_target;
      rsp_type   pending_drives[$];
      int unsigned faults;

      function new();
         cfg = '0;
         cfg.mode = MODE_POS;
         last_err = 0;
         older_err = 0;
         err_total = 0;
         slope_q8 = 0;
         last_target = 0;
         faults = 0;
      endfunction

      function longint clamp_to(longint v, longint cap);
         if (v > cap) return cap;
         if (v < -cap) return -cap;
         return v;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_MODE:    cfg.mode = val[1:0];
            CSR_GAIN_P:  cfg.gain_p = val[15:0];
            CSR_GAIN_I:  cfg.gain_i = val[15:0];
            CSR_GAIN_D:  cfg.gain_d = val[15:0];
            CSR_GAIN_FF: cfg.gain_ff = val[15:0];
            CSR_ICAP:    cfg.integral_cap = val[23:0];
            CSR_DCAP:    cfg.drive_cap = val[14:0];
            CSR_DBAND:   cfg.dead_band = val[15:0];
            default: ;
         endcase
      endfunction

      // works out the drive for one accepted sample and queues it
      function void take_sample(req_type s);
         longint  e, tgt, kp, ki, kd, kf, icap, p, i, d, f, total, mag;
         rsp_type r;
         tgt = longint'(s.target);
         e = tgt - longint'(s.measured);
         kp = longint'($signed(cfg.gain_p));
         ki = longint'($signed(cfg.gain_i));
         kd = longint'($signed(cfg.gain_d));
         kf = longint'($signed(cfg.gain_ff));
         icap = longint'(cfg.integral_cap);
         r = '0;
         case (cfg.mode)
            MODE_INCR: begin
               p = (kp * (e - last_err)) >>> GAIN_FRAC;
               i = clamp_to((ki * e) >>> GAIN_FRAC, icap);
               d = (kd * (e - 2 * last_err + older_err)) >>> GAIN_FRAC;
               total = p + i + d;
               older_err = last_err;
               last_err = e;
            end
            MODE_FF: begin
               mag = (e < 0) ? -e : e;
               if (mag < longint'(cfg.dead_band)) begin
                  total = 0;
                  r.in_dead_band = 1'b1;
               end else begin
                  p = (kp * e) >>> GAIN_FRAC;
                  err_total = clamp_to(err_total + e, icap);
                  i = (ki * err_total) >>> GAIN_FRAC;
                  slope_q8 = (SMOOTH_NEW * ((e - last_err) * 256) + SMOOTH_OLD * slope_q8) >>> 8;
                  d = (kd * slope_q8) >>> (GAIN_FRAC + 8);
                  f = (kf * (tgt - last_target)) >>> GAIN_FRAC;
                  total = p + i + d + f;
                  last_err = e;
                  last_target = tgt;
               end
            end
            default: begin
               p = (kp * e) >>> GAIN_FRAC;
               err_total = clamp_to(err_total + e, icap);
               i = (ki * err_total) >>> GAIN_FRAC;
               d = (kd * (e - last_err)) >>> GAIN_FRAC;
               total = p + i + d;
               last_err = e;
            end
         endcase
         total = clamp_to(total, longint'(cfg.drive_cap));
         r.drive = total[15:0];
         pending_drives.push_back(r);
      endfunction

      function void match_drive(rsp_type got);
         rsp_type want;
         if (pending_drives.size() == 0) begin
            $error("result item with no drive pending: drive %0d", got.drive);
            faults++;
            return;
         end
         want = pending_drives.pop_front();
         if (got.drive !== want.drive) begin
            $error("drive: expected %0d, actual %0d", want.drive, got.drive);
            faults++;
         end
         if (got.in_dead_band !== want.in_dead_band) begin
            $error("in_dead_band: expected %0d, actual %0d", want.in_dead_band,
                   got.in_dead_band);
            faults++;
         end
      endfunction

      function int open_count();
         return pending_drives.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_item;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_item;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   drive_book   book;
   cfg_type     active;       // settings in force, used to shape the samples
   bit          steady;       // no idling on either side in this phase
   bit          long_hold;    // asks the result sink for one long stall
   int unsigned cycle_count = 0;

   pid_controller_three_mode #(
      .GAIN_FRAC_BITS(GAIN_FRAC)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog, far above the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // both handshakes are sampled at the edge; results are matched before the
   // new sample is booked so a stray result cannot pair with a fresh item
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) book.match_drive(rsp_item);
         if (req_valid && req_ready) book.take_sample(req_item);
      end
   end

   // result sink: draws a stall before each item, or one long hold-off on request
   initial begin : result_sink
      int unsigned stall;
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold) begin
            stall = LONG_HOLD;
            long_hold = 1'b0;
         end else begin
            stall = steady ? 0 : $urandom_range(0, 17);
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // saturate an integer into the sample range
   function automatic logic signed [SAMPLE_WIDTH-1:0] to_sample(int v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[SAMPLE_WIDTH-1:0];
   endfunction

   function automatic req_type make_sample(int meas, int tgt);
      req_type s;
      s.measured = to_sample(meas);
      s.target = to_sample(tgt);
      return s;
   endfunction

   function automatic cfg_type make_settings(logic [1:0] md, int gp, int gi, int gd,
                                             int gf, int icap, int dcap, int dband);
      cfg_type c;
      c.mode = md;
      c.gain_p = gp[15:0];
      c.gain_i = gi[15:0];
      c.gain_d = gd[15:0];
      c.gain_ff = gf[15:0];
      c.integral_cap = icap[23:0];
      c.drive_cap = dcap[14:0];
      c.dead_band = dband[15:0];
      return c;
   endfunction

   // gains lean towards the extremes, small values and values near unity
   function automatic logic signed [GAIN_W-1:0] pick_gain();
      int g;
      case ($urandom_range(0, 5))
         0: g = -32768;
         1: g = 32767;
         2: g = int'($urandom_range(0, 1023)) - 512;
         3: g = int'($urandom_range(0, 2048));
         default: g = int'($urandom_range(0, 65535)) - 32768;
      endcase
      return g[15:0];
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      c.mode = 2'($urandom_range(0, 3));
      c.gain_p = pick_gain();
      c.gain_i = pick_gain();
      c.gain_d = pick_gain();
      c.gain_ff = pick_gain();
      case ($urandom_range(0, 5))
         0: c.integral_cap = '0;
         1: c.integral_cap = '1;
         2, 3: c.integral_cap = 24'($urandom_range(1, 4095));
         default: c.integral_cap = 24'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0: c.drive_cap = '0;
         1, 2: c.drive_cap = '1;
         default: c.drive_cap = 15'($urandom_range(1, 32767));
      endcase
      case ($urandom_range(0, 6))
         0: c.dead_band = '0;
         1: c.dead_band = '1;
         2: c.dead_band = 16'($urandom_range(1, 64));
         3, 4: c.dead_band = 16'($urandom_range(1, 2000));
         default: c.dead_band = 16'($urandom);
      endcase
      return c;
   endfunction

   // mostly errors near the dead band edge or small tracking errors,
   // the rest spread over the whole sample range
   function automatic req_type random_sample();
      int tgt, meas, off;
      tgt = int'($urandom_range(0, 65535)) - 32768;
      case ($urandom_range(0, 3))
         0: meas = int'($urandom_range(0, 65535)) - 32768;
         1: begin
            off = int'(active.dead_band) + int'($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 1) == 1) off = -off;
            meas = tgt - off;
         end
         default: meas = tgt - (int'($urandom_range(0, 400)) - 200);
      endcase
      return make_sample(meas, tgt);
   endfunction

   // every register each time; the write enable drops once after the last
   task automatic load_settings(input cfg_type c);
      logic [CSR_IDX_W-1:0]  idx [8];
      logic [CSR_DATA_W-1:0] val [8];
      idx[0] = CSR_MODE;    val[0] = {22'd0, c.mode};
      idx[1] = CSR_GAIN_P;  val[1] = {8'd0, c.gain_p};
      idx[2] = CSR_GAIN_I;  val[2] = {8'd0, c.gain_i};
      idx[3] = CSR_GAIN_D;  val[3] = {8'd0, c.gain_d};
      idx[4] = CSR_GAIN_FF; val[4] = {8'd0, c.gain_ff};
      idx[5] = CSR_ICAP;    val[5] = c.integral_cap;
      idx[6] = CSR_DCAP;    val[6] = {9'd0, c.drive_cap};
      idx[7] = CSR_DBAND;   val[7] = {8'd0, c.dead_band};
      for (int n = 0; n < 8; n++) begin
         csr_we <= 1'b1;
         csr_index <= idx[n];
         csr_wdata <= val[n];
         book.set_register(idx[n], val[n]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      active = c;
   endtask

   // offers one item after a drawn gap and returns at the edge that takes it
   task automatic send_sample(input req_type s);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // sender pauses until every booked drive has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (book.open_count() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   initial begin
      int unsigned random_sent;
      int unsigned phase;
      int unsigned count;
      book = new();
      active = '0;
      active.mode = MODE_POS;
      steady = 1'b0;
      long_hold = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // settings straight out of reset: positional with a zero drive cap
      send_sample(make_sample(100, -100));
      send_sample(make_sample(-32768, 32767));
      drain();

      // positional, largest gains and caps, widest errors build up the sum
      load_settings(make_settings(MODE_POS, 32767, 32767, 32767, 0, 24'hFFFFFF, 32767, 0));
      send_sample(make_sample(-32768, 32767));
      send_sample(make_sample(32767, -32768));
      send_sample(make_sample(0, 0));
      send_sample(make_sample(-32768, 32767));
      drain();

      // incremental, most negative gains, a tight clamp on the i term
      load_settings(make_settings(MODE_INCR, -32768, -32768, -32768, 0, 100, 32767, 0));
      send_sample(make_sample(32767, -32768));
      send_sample(make_sample(-32768, 32767));
      send_sample(make_sample(0, 0));
      send_sample(make_sample(5, -7));
      drain();

      // dead band: errors just inside and just on its edge, both signs,
      // then large setpoint steps for the feedforward path
      load_settings(make_settings(MODE_FF, 256, 64, 512, -32768, 5000, 20000, 1000));
      send_sample(make_sample(0, 999));
      send_sample(make_sample(0, 1000));
      send_sample(make_sample(500, -499));
      send_sample(make_sample(1000, 0));
      send_sample(make_sample(-32768, 32767));
      send_sample(make_sample(0, -32768));
      drain();

      // the spare mode code with both caps at zero
      load_settings(make_settings(MODE_SPARE, 1000, 1000, 1000, 1000, 0, 0, 0));
      send_sample(make_sample(1, 2));
      send_sample(make_sample(-32768, 32767));
      send_sample(make_sample(32767, -32768));
      drain();

      // feedforward mode with no dead band: a zero error is still live
      load_settings(make_settings(MODE_FF, 32767, -32768, 32767, 32767, 0, 32767, 0));
      send_sample(make_sample(3, 3));
      send_sample(make_sample(-32768, 32767));
      send_sample(make_sample(32767, -32768));
      drain();

      // random phases, each with fresh settings; two of them stall the sink
      // long enough for the block to fill and push back on the sender
      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         load_settings(random_settings());
         steady = ($urandom_range(0, 4) == 0);
         if (phase == 2 || phase == 11) begin
            steady = 1'b1;
            long_hold = 1'b1;
         end
         count = $urandom_range(10, 60);
         repeat (count) send_sample(random_sample());
         random_sent += count;
         drain();
         steady = 1'b0;
         phase++;
      end

      repeat (8) @(posedge clock);
      if (book.faults == 0 && book.open_count() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
